// File: src/skset_pkg.sv
// Package for the sorted key set: sizes, opcodes, status codes and beat types.
// Used by skset_cmp and sorted_key_set; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package skset_pkg;

	localparam int SLOTS    = 256;
	localparam int CAPACITY = SLOTS - 1;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int KEY_W    = 32;

	localparam logic [1:0] OP_SEARCH = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] position;
	} rsp_t;

	typedef struct packed {
		logic             less;
		logic             equal;
		logic [IDX_W-1:0] mid;
	} cmp_t;

endpackage
`default_nettype wire

// File: src/skset_cmp.sv
// Shared compare unit: probe midpoint of the search window and key compare.
// Depends on skset_pkg.
`timescale 1ns / 1ps
`default_nettype none
module skset_cmp (
	input  wire logic [skset_pkg::KEY_W-1:0] stored,
	input  wire logic [skset_pkg::KEY_W-1:0] key,
	input  wire logic [skset_pkg::IDX_W-1:0] lo,
	input  wire logic [skset_pkg::IDX_W-1:0] hi,
	output skset_pkg::cmp_t                  res
);

	logic [skset_pkg::IDX_W:0] sum;

	assign sum       = {1'b0, lo} + {1'b0, hi};
	assign res.mid   = sum[skset_pkg::IDX_W:1];
	assign res.less  = stored < key;
	assign res.equal = stored == key;

endmodule
`default_nettype wire

// File: src/sorted_key_set.sv
// Sorted key set top level: sequencer, key memory and response register.
// Depends on skset_pkg and skset_cmp.
//
// Holds an ascending, duplicate-free set of up to SLOTS-1 32-bit keys in a
// single-port-write, registered-read memory. Each request beat is a search,
// an insert or a remove and returns one response beat with a status and the
// key's index. The key's place is found by binary search through one shared
// comparator: each probe reads the midpoint key, then compares it and narrows
// the window. An insert or remove then moves each later key one slot, one key
// per cycle through the memory's read and write ports. req_stall is high for
// the whole of a request; a finished response waits in its own register, so
// the next request is taken while the previous response is still stalled.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_set (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire skset_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output skset_pkg::rsp_t     rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_CMP,
		S_CHECK,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_RESP
	} state_t;

	state_t                          state_q;
	logic [1:0]                      op_q;
	logic [skset_pkg::KEY_W-1:0]     key_q;
	logic [skset_pkg::IDX_W-1:0]     lo_q, hi_q, at_q, ptr_q, count_q, wr_addr_q;
	logic                            wr_pend_q;
	logic [1:0]                      res_status_q;
	logic [7:0]                      res_pos_q;
	logic                            rsp_valid_q;
	skset_pkg::rsp_t                 rsp_q;

	logic [skset_pkg::KEY_W-1:0]     mem [skset_pkg::CAPACITY];
	logic [skset_pkg::KEY_W-1:0]     rd_q;
	logic                            re, we;
	logic [skset_pkg::IDX_W-1:0]     raddr, waddr;
	logic [skset_pkg::KEY_W-1:0]     wdata;

	skset_pkg::cmp_t                 cmp;
	logic                            found;
	logic                            dn_more;
	logic                            full;
	logic                            rsp_load;

	skset_cmp u_cmp (
		.stored(rd_q),
		.key   (key_q),
		.lo    (lo_q),
		.hi    (hi_q),
		.res   (cmp)
	);

	assign found    = (at_q < count_q) && cmp.equal;
	assign dn_more  = ({1'b0, ptr_q} + 1'b1) < {1'b0, count_q};
	assign full     = count_q == skset_pkg::IDX_W'(skset_pkg::CAPACITY);
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = wr_addr_q;
		wdata = rd_q;
		case (state_q)
			S_PROBE: begin
				if (lo_q < hi_q) begin
					re    = 1'b1;
					raddr = cmp.mid;
				end else if (lo_q < count_q) begin
					re    = 1'b1;
					raddr = lo_q;
				end
			end
			S_SHIFT_UP: begin
				if (wr_pend_q) begin
					we = 1'b1;
				end else if (ptr_q == at_q) begin
					we    = 1'b1;
					waddr = at_q;
					wdata = key_q;
				end
				if (ptr_q > at_q) begin
					re    = 1'b1;
					raddr = ptr_q - 1'b1;
				end
			end
			S_SHIFT_DN: begin
				we = wr_pend_q;
				if (dn_more) begin
					re    = 1'b1;
					raddr = ptr_q + 1'b1;
				end
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			wr_pend_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.op;
						key_q   <= req.key;
						lo_q    <= '0;
						hi_q    <= count_q;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else begin
						at_q    <= lo_q;
						state_q <= S_CHECK;
					end
				end
				S_CMP: begin
					if (cmp.less) begin
						lo_q <= cmp.mid + 1'b1;
					end else begin
						hi_q <= cmp.mid;
					end
					state_q <= S_PROBE;
				end
				S_CHECK: begin
					res_pos_q    <= 8'(at_q);
					res_status_q <= skset_pkg::ST_DONE;
					wr_pend_q    <= 1'b0;
					state_q      <= S_RESP;
					if (op_q == skset_pkg::OP_INSERT) begin
						if (found) begin
							res_status_q <= skset_pkg::ST_DUP;
						end else if (full) begin
							res_status_q <= skset_pkg::ST_FULL;
							res_pos_q    <= '0;
						end else begin
							ptr_q   <= count_q;
							state_q <= S_SHIFT_UP;
						end
					end else if (op_q == skset_pkg::OP_REMOVE && found) begin
						ptr_q   <= at_q;
						state_q <= S_SHIFT_DN;
					end else if (!found) begin
						res_status_q <= skset_pkg::ST_MISSING;
						res_pos_q    <= '0;
					end
				end
				S_SHIFT_UP: begin
					wr_pend_q <= ptr_q > at_q;
					if (ptr_q > at_q) begin
						wr_addr_q <= ptr_q;
						ptr_q     <= ptr_q - 1'b1;
					end else if (!wr_pend_q) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RESP;
					end
				end
				S_SHIFT_DN: begin
					wr_pend_q <= dn_more;
					if (dn_more) begin
						wr_addr_q <= ptr_q;
						ptr_q     <= ptr_q + 1'b1;
					end else if (!wr_pend_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_load) begin
						rsp_q.status   <= res_status_q;
						rsp_q.position <= res_pos_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
